[rtl/core/gfau_pkg.sv]
`timescale 1ns / 1ps

package gfau_pkg;

    localparam int MAX_FIELD_BITS = 12;
    localparam int MIN_FIELD_BITS = 2;
    localparam int ELEM_W         = MAX_FIELD_BITS;
    localparam int POLY_W         = MAX_FIELD_BITS + 1;
    localparam int BITS_W         = 4;
    localparam int CFG_DATA_W     = POLY_W;
    localparam int CFG_INDEX_W    = 2;
    localparam int TABLE_DEPTH    = 1 << MAX_FIELD_BITS;

    localparam logic [POLY_W-1:0] RESET_POLYNOMIAL = 13'h011D;
    localparam logic [BITS_W-1:0] RESET_BITS       = 4'd8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_POLYNOMIAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_BITS       = 2'd1;

    // operation codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_MULTIPLY = 3'd1;
    localparam logic [2:0] OP_ANTILOG  = 3'd2;
    localparam logic [2:0] OP_LOG      = 3'd3;
    localparam logic [2:0] OP_INVERSE  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ZERO    = 2'd1;
    localparam logic [1:0] ERR_OPERAND = 2'd2;

    typedef struct packed {
        logic [2:0]        operation;
        logic [ELEM_W-1:0] operand_a;
        logic [ELEM_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [ELEM_W-1:0] result;
        logic [1:0]        error_code;
    } out_word_t;

    // Clamp m into the supported range.
    function automatic logic [BITS_W-1:0] width_in_use(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] m;
        m = bits;
        if (m < BITS_W'(MIN_FIELD_BITS))
            m = BITS_W'(MIN_FIELD_BITS);
        if (m > BITS_W'(MAX_FIELD_BITS))
            m = BITS_W'(MAX_FIELD_BITS);
        return m;
    endfunction

endpackage

[rtl/core/galois_field_arith_unit_core.sv]
`timescale 1ns / 1ps

// GF(2^m) arithmetic unit, generator alpha = 2.
// Input channel in_valid/in_ready carries one word: operation, operand_a, operand_b.
// Output channel out_valid/out_ready carries one word: result, error_code.
// Configuration: cfg_write with cfg_index/cfg_data writes field_polynomial
// (index 0) or field_bits (index 1); write only while idle. Reset, and any
// write to either register, drops the tables. The block then runs a build
// (clear the log table, then walk alpha^i by shift-and-reduce, writing the
// antilog and log tables one entry a cycle); in_ready stays low throughout.
// Reset default field: m = 8, polynomial 0x11D. Once built, the block takes
// one word at a time: log-table read at the accepting edge, antilog-table
// read, then the result register, which raises out_valid as in_ready
// returns. The two dependent reads of the synchronous table memories set
// these steps. While the receiver stalls, the finished word holds in the
// output register and the next word is still accepted and looked up; it then
// waits in the final stage until the output register frees.
module galois_field_arith_unit_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [gfau_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gfau_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  gfau_pkg::in_word_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output gfau_pkg::out_word_t                    out_data
);
    import gfau_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_LOOKUP = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;

    // table memories
    logic [ELEM_W-1:0] antilog_mem [TABLE_DEPTH];
    logic [ELEM_W-1:0] log_mem     [TABLE_DEPTH];

    // control state
    logic [2:0]        state_reg, state_next;
    logic              tables_ready_reg, tables_ready_next;
    logic              out_valid_reg, out_valid_next;
    logic [POLY_W-1:0] poly_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [ELEM_W-1:0] cnt_reg, cnt_next;
    logic [ELEM_W-1:0] x_reg, x_next;

    // payload
    in_word_t          item_reg;
    logic [1:0]        err_reg, err_next;
    logic [ELEM_W-1:0] anti_idx_reg, anti_idx_next;
    out_word_t         out_reg, out_next;
    logic [ELEM_W-1:0] log_a_reg, log_b_reg, anti_rd_reg;

    // derived field figures
    logic [BITS_W-1:0] m;
    logic [ELEM_W-1:0] mask;
    logic [POLY_W-1:0] mask_w;

    // memory ports
    logic              anti_we, log_we;
    logic [ELEM_W-1:0] anti_wa, anti_wd, log_wa, log_wd;
    logic [ELEM_W-1:0] log_ra, log_rb, anti_ra;

    logic              accept;
    logic              cfg_hit;
    logic              out_free;
    logic [POLY_W-1:0] x_shift;
    logic [POLY_W-1:0] log_sum;
    logic [1:0]        err_in;

    assign m      = width_in_use(bits_reg);
    assign mask_w = (POLY_W'(1) << m) - POLY_W'(1);
    assign mask   = mask_w[ELEM_W-1:0];

    assign in_ready  = (state_reg == S_IDLE) && tables_ready_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_hit   = cfg_write &&
                       (cfg_index == REG_FIELD_POLYNOMIAL || cfg_index == REG_FIELD_BITS);

    // next alpha power: shift, reduce when the x^m bit appears
    assign x_shift = {x_reg, 1'b0};

    // log sum modulo 2^m - 1: both terms are at most 2^m - 2
    assign log_sum = POLY_W'(log_a_reg) + POLY_W'(log_b_reg);

    // classify the incoming word
    always_comb
    begin
        err_in = ERR_NONE;
        if (in_data.operation > OP_INVERSE
            || (in_data.operand_a & ~mask) != '0
            || ((in_data.operation == OP_ADD || in_data.operation == OP_MULTIPLY)
                && (in_data.operand_b & ~mask) != '0))
            err_in = ERR_OPERAND;
        else if ((in_data.operation == OP_LOG || in_data.operation == OP_INVERSE)
                 && in_data.operand_a == '0)
            err_in = ERR_ZERO;
    end

    // read addresses: take operands straight from the port while idle
    assign log_ra  = (state_reg == S_IDLE) ? in_data.operand_a : item_reg.operand_a;
    assign log_rb  = (state_reg == S_IDLE) ? in_data.operand_b : item_reg.operand_b;
    // issue the antilog read with the index as it is formed, then hold it
    assign anti_ra = (state_reg == S_LOOKUP) ? anti_idx_next : anti_idx_reg;

    // build writes
    always_comb
    begin
        anti_we = 1'b0;
        anti_wa = cnt_reg;
        anti_wd = x_reg;
        log_we  = 1'b0;
        log_wa  = cnt_reg;
        log_wd  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                log_we = 1'b1;
            end
            S_FILL:
            begin
                anti_we = 1'b1;
                // the last power wraps to one; leave its log entry alone
                log_we  = (cnt_reg != mask);
                log_wa  = x_reg;
                log_wd  = cnt_reg;
            end
            default:
            begin
                anti_we = 1'b0;
                log_we  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        tables_ready_next = tables_ready_reg;
        out_valid_next    = out_valid_reg;
        cnt_next          = cnt_reg;
        x_next            = x_reg;
        err_next          = err_reg;
        anti_idx_next     = anti_idx_reg;
        out_next          = out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!tables_ready_reg)
                begin
                    state_next = S_CLEAR;
                    cnt_next   = '0;
                end
                else if (accept)
                begin
                    state_next = S_LOOKUP;
                    err_next   = err_in;
                end
            end
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mask)
                begin
                    state_next = S_FILL;
                    cnt_next   = '0;
                    x_next     = ELEM_W'(1);
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if ((x_shift & ~mask_w) != '0)
                    x_next = ELEM_W'((x_shift ^ poly_reg) & mask_w);
                else
                    x_next = x_shift[ELEM_W-1:0];
                if (cnt_reg == mask)
                begin
                    state_next        = S_IDLE;
                    tables_ready_next = 1'b1;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_READ;
                case (item_reg.operation)
                    OP_MULTIPLY:
                    begin
                        if (log_sum >= mask_w)
                            anti_idx_next = ELEM_W'(log_sum - mask_w);
                        else
                            anti_idx_next = log_sum[ELEM_W-1:0];
                    end
                    OP_INVERSE:
                    begin
                        anti_idx_next = mask - log_a_reg;
                    end
                    default:
                    begin
                        anti_idx_next = item_reg.operand_a;
                    end
                endcase
            end
            S_READ:
            begin
                if (out_free)
                begin
                    state_next          = S_IDLE;
                    out_valid_next      = 1'b1;
                    out_next.error_code = err_reg;
                    out_next.result     = '0;
                    if (err_reg == ERR_NONE)
                    begin
                        case (item_reg.operation)
                            OP_ADD:
                                out_next.result = item_reg.operand_a ^ item_reg.operand_b;
                            OP_MULTIPLY:
                                if (item_reg.operand_a != '0 && item_reg.operand_b != '0)
                                    out_next.result = anti_rd_reg;
                            OP_LOG:
                                out_next.result = log_a_reg;
                            default:
                                out_next.result = anti_rd_reg;
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write drops the tables and restarts any build in progress
        if (cfg_hit)
        begin
            tables_ready_next = 1'b0;
            if (state_reg == S_CLEAR || state_reg == S_FILL)
                state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tables_ready_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            poly_reg         <= RESET_POLYNOMIAL;
            bits_reg         <= RESET_BITS;
            cnt_reg          <= '0;
            x_reg            <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            tables_ready_reg <= tables_ready_next;
            out_valid_reg    <= out_valid_next;
            cnt_reg          <= cnt_next;
            x_reg            <= x_next;
            if (cfg_write && cfg_index == REG_FIELD_POLYNOMIAL)
                poly_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_FIELD_BITS)
                bits_reg <= cfg_data[BITS_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        err_reg      <= err_next;
        anti_idx_reg <= anti_idx_next;
        out_reg      <= out_next;
    end

    // antilog memory
    always_ff @(posedge clk)
    begin
        if (anti_we)
            antilog_mem[anti_wa] <= anti_wd;
        anti_rd_reg <= antilog_mem[anti_ra];
    end

    // log memory: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (log_we)
            log_mem[log_wa] <= log_wd;
        log_a_reg <= log_mem[log_ra];
        log_b_reg <= log_mem[log_rb];
    end

`ifndef SYNTH
    // no word may enter before the tables are built
    a_ready_needs_tables: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> tables_ready_reg)
        else $error("input accepted without built tables");

    // a register write blocks input on the next cycle
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready)
        else $error("input ready straight after a register write");

    // build counter stays inside the field
    a_build_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR || state_reg == S_FILL) |-> cnt_reg <= mask)
        else $error("build counter beyond field size");

    // any error reports a zero result
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code != ERR_NONE) |-> out_data.result == '0)
        else $error("non-zero result with an error");
`endif

endmodule

[verif/gf_arith_checker.sv]
`timescale 1ns / 1ps

module gf_arith_checker
    import gfau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_word_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_word_t              out_data,
    output int unsigned            mismatches,
    output int unsigned            outstanding,
    output int unsigned            words_checked,
    output int unsigned            flagged_words
);

    logic [POLY_W-1:0] poly_q;
    logic [BITS_W-1:0] bits_q;
    logic              tables_built;
    logic [ELEM_W-1:0] alpha_power  [TABLE_DEPTH];
    logic [ELEM_W-1:0] discrete_log [TABLE_DEPTH];
    out_word_t         expected_words [$];

    function automatic int unsigned active_width();
        int unsigned m;
        m = bits_q;
        if (m < MIN_FIELD_BITS)
            m = MIN_FIELD_BITS;
        if (m > MAX_FIELD_BITS)
            m = MAX_FIELD_BITS;
        return m;
    endfunction

    // Walk alpha^i by shift-and-reduce; later indices win in the log table.
    function automatic void rebuild_tables();
        int unsigned size;
        int unsigned x;
        size = 1 << active_width();
        x = 1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            discrete_log[i] = '0;
        for (int unsigned i = 0; i < size; i++)
        begin
            alpha_power[i] = ELEM_W'(x);
            x = x << 1;
            if (x >= size)
                x = (x ^ poly_q) & (size - 1);
        end
        for (int unsigned i = 0; i + 1 < size; i++)
            discrete_log[alpha_power[i]] = ELEM_W'(i);
    endfunction

    function automatic out_word_t gf_predict(in_word_t w);
        out_word_t   r;
        int unsigned size;
        int unsigned a;
        int unsigned b;
        int unsigned s;
        if (!tables_built)
        begin
            rebuild_tables();
            tables_built = 1'b1;
        end
        size = 1 << active_width();
        a = w.operand_a;
        b = w.operand_b;
        r.result = '0;
        r.error_code = ERR_NONE;
        if (w.operation > OP_INVERSE || a >= size ||
            ((w.operation == OP_ADD || w.operation == OP_MULTIPLY) && b >= size))
            r.error_code = ERR_OPERAND;
        else
            case (w.operation)
                OP_ADD:
                    r.result = ELEM_W'(a ^ b);
                OP_MULTIPLY:
                    if (a != 0 && b != 0)
                    begin
                        s = discrete_log[a] + discrete_log[b];
                        r.result = alpha_power[s % (size - 1)];
                    end
                OP_ANTILOG:
                    r.result = alpha_power[a];
                default:
                    if (a == 0)
                        r.error_code = ERR_ZERO;
                    else if (w.operation == OP_LOG)
                        r.result = discrete_log[a];
                    else
                        r.result = alpha_power[size - 1 - discrete_log[a]];
            endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_word;
        if (!rst_n)
        begin
            poly_q        = RESET_POLYNOMIAL;
            bits_q        = RESET_BITS;
            tables_built  = 1'b0;
            expected_words.delete();
            mismatches    = 0;
            outstanding   = 0;
            words_checked = 0;
            flagged_words = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing outstanding: result %0d, error_code %0d",
                           out_data.result, out_data.error_code);
                    mismatches++;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    words_checked++;
                    if (out_data.result !== exp_word.result)
                    begin
                        $error("result: expected %0d, got %0d",
                               exp_word.result, out_data.result);
                        mismatches++;
                    end
                    if (out_data.error_code !== exp_word.error_code)
                    begin
                        $error("error_code: expected %0d, got %0d",
                               exp_word.error_code, out_data.error_code);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                exp_word = gf_predict(in_data);
                if (exp_word.error_code != ERR_NONE)
                    flagged_words++;
                expected_words.push_back(exp_word);
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_FIELD_POLYNOMIAL)
                begin
                    poly_q = cfg_data[POLY_W-1:0];
                    tables_built = 1'b0;
                end
                else if (cfg_index == REG_FIELD_BITS)
                begin
                    bits_q = cfg_data[BITS_W-1:0];
                    tables_built = 1'b0;
                end
            end
            outstanding = expected_words.size();
        end
    end

endmodule

[verif/galois_field_arith_unit_core_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the GF(2^m) arithmetic unit. All prediction and
// comparison lives in the checker beside the block; this module only drives
// the three ports, steers the idling pattern and decides pass or fail.
module galois_field_arith_unit_core_tb;

    import gfau_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    // Long receiver hold-off, enough to fill the pipe and back up the input.
    localparam int LONG_HOLD      = 300;
    // Settle time after the last word: three-stage pipe plus margin.
    localparam int SETTLE_CYCLES  = 8;

    // Register slots past the two real ones; writes there must do nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    // Operation codes that the block does not define.
    localparam logic [2:0] OP_RESERVED_5 = 3'd5;
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_word_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned words_checked;
    int unsigned flagged_words;

    // Idle percentages for each side, and the current field size for operands.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned field_size    = 256;
    int unsigned settings_run  = 1;
    int unsigned cycle_count   = 0;
    logic        hold_active   = 1'b0;
    event        hold_off_kick;

    galois_field_arith_unit_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    gf_arith_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .flagged_words (flagged_words)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: abandon the run if it hangs anywhere.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: one decision per cycle on the falling edge; the long hold-off
    // overrides the random stalls while it runs.
    always @(negedge clk)
        out_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);

    // Long hold-off, counted here so the sender carries on meanwhile. Flip the
    // flag on rising edges so it never races the receiver's falling-edge draw.
    initial
    begin
        forever
        begin
            @(hold_off_kick);
            @(posedge clk);
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    function automatic in_word_t word_of(logic [2:0] op, logic [ELEM_W-1:0] a,
                                         logic [ELEM_W-1:0] b);
        in_word_t w;
        w.operation = op;
        w.operand_a = a;
        w.operand_b = b;
        return w;
    endfunction

    // Mostly in-field values, with zero, the top element and the full 12-bit
    // range mixed in so the out-of-field and zero paths keep getting hit.
    function automatic logic [ELEM_W-1:0] pick_operand(int unsigned size);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 16)
            return ELEM_W'($urandom_range(TABLE_DEPTH - 1, 0));
        if (roll < 20)
            return ELEM_W'(size - 1);
        return ELEM_W'($urandom_range(size - 1, 0));
    endfunction

    // Offer one word; leave valid high on return so the next word can follow
    // back to back without dropping it in between.
    task automatic send_word(input in_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        logic [2:0] op;
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 7)
                op = 3'($urandom_range(OP_RESERVED_7, OP_RESERVED_5));
            else
                op = 3'($urandom_range(OP_INVERSE, OP_ADD));
            send_word(word_of(op, pick_operand(field_size), pick_operand(field_size)));
        end
        end_burst();
    endtask

    // Wait for every outstanding word to come back before touching config.
    task automatic drain();
        wait (outstanding == 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_field(input logic [POLY_W-1:0] poly, input logic [BITS_W-1:0] bits);
        int unsigned m;
        write_reg(REG_FIELD_POLYNOMIAL, poly);
        write_reg(REG_FIELD_BITS, CFG_DATA_W'(bits));
        m = bits;
        if (m < MIN_FIELD_BITS)
            m = MIN_FIELD_BITS;
        if (m > MAX_FIELD_BITS)
            m = MAX_FIELD_BITS;
        field_size = 1 << m;
        settings_run++;
    endtask

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        set_idle(20, 71);

        // Directed words on the reset field (m = 8, x^8+x^4+x^3+x^2+1).
        send_word(word_of(OP_ADD, 12'd0, 12'd0));
        send_word(word_of(OP_ADD, 12'd255, 12'd255));
        send_word(word_of(OP_ADD, 12'h0AA, 12'h055));
        send_word(word_of(OP_MULTIPLY, 12'd0, 12'd37));
        send_word(word_of(OP_MULTIPLY, 12'd37, 12'd0));
        send_word(word_of(OP_MULTIPLY, 12'd255, 12'd255));
        send_word(word_of(OP_MULTIPLY, 12'd2, 12'd128));
        send_word(word_of(OP_MULTIPLY, 12'd1, 12'd1));
        // Antilog ignores operand_b, so an out-of-field b must pass.
        send_word(word_of(OP_ANTILOG, 12'd0, 12'hFFF));
        send_word(word_of(OP_ANTILOG, 12'd254, 12'd0));
        send_word(word_of(OP_ANTILOG, 12'd255, 12'd0));
        // Log and inverse of zero flag the zero error.
        send_word(word_of(OP_LOG, 12'd0, 12'd0));
        send_word(word_of(OP_LOG, 12'd1, 12'd0));
        send_word(word_of(OP_LOG, 12'd255, 12'd0));
        send_word(word_of(OP_INVERSE, 12'd0, 12'd0));
        send_word(word_of(OP_INVERSE, 12'd1, 12'd0));
        send_word(word_of(OP_INVERSE, 12'd255, 12'd0));
        // Operands just past the field and at the very top of the range.
        send_word(word_of(OP_ADD, 12'd256, 12'd0));
        send_word(word_of(OP_ADD, 12'd0, 12'd256));
        send_word(word_of(OP_MULTIPLY, 12'hFFF, 12'd1));
        send_word(word_of(OP_MULTIPLY, 12'd1, 12'hFFF));
        send_word(word_of(OP_LOG, 12'hFFF, 12'd0));
        // Undefined operation codes.
        send_word(word_of(OP_RESERVED_5, 12'd3, 12'd3));
        send_word(word_of(OP_RESERVED_6, 12'd0, 12'd0));
        send_word(word_of(OP_RESERVED_7, 12'hFFF, 12'hFFF));
        end_burst();

        run_random(150);
        drain();

        // Smallest field.
        set_field(13'h0007, 4'd2);
        run_random(60);
        drain();

        // Swap the idling: sender idles heavily, receiver lightly.
        set_idle(71, 20);

        // Largest field, then a width above the maximum with an all-ones
        // polynomial, then a width below the minimum with a zero polynomial.
        set_field(13'h1053, 4'd12);
        run_random(120);
        drain();
        set_field(13'h1FFF, 4'd15);
        run_random(60);
        drain();
        set_field(13'h0000, 4'd0);
        run_random(40);
        drain();

        // No idling on either side from here on.
        set_idle(0, 0);

        // Non-primitive polynomial; stall the receiver for a long stretch so
        // the block fills and drops in_ready.
        set_field(13'h001F, 4'd4);
        -> hold_off_kick;
        run_random(60);
        drain();

        // Writes to the spare slots must leave the built tables alone.
        set_field(13'h0025, 4'd5);
        run_random(40);
        drain();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, 13'h0123);
        -> hold_off_kick;
        run_random(40);
        drain();

        set_field(13'h0409, 4'd10);
        run_random(80);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d words (%0d flagged with an error) over %0d field settings,",
                 words_checked, flagged_words, settings_run);
        $display("m clamped at both ends, degenerate polynomials and spare register writes.");
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
